FILE: rtl/flp_pkg.sv
package flp_pkg;

	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_GS    = 8'h1D;
	localparam logic [7:0] CH_RS    = 8'h1E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] INT_CODE_RESET = 8'd1;
	localparam logic [7:0] STR_CODE_RESET = 8'd2;

	localparam int TDATA_W = 80;
	localparam int TUSER_W = 2;

	localparam logic KIND_INT  = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	// Register word index, taken from paddr[2].
	localparam logic REG_INT_CODE = 1'b0;
	localparam logic REG_STR_CODE = 1'b1;

	typedef enum logic [7:0] {
		PH_STANDBY = 8'b0000_0001,
		PH_STAMP   = 8'b0000_0010,
		PH_NAME    = 8'b0000_0100,
		PH_TYPE    = 8'b0000_1000,
		PH_INT     = 8'b0001_0000,
		PH_NEG     = 8'b0010_0000,
		PH_TEXT    = 8'b0100_0000,
		PH_SKIP    = 8'b1000_0000
	} phase_t;

	typedef enum logic [5:0] {
		SQ_IDLE = 6'b00_0001,
		SQ_STEP = 6'b00_0010,
		SQ_INT  = 6'b00_0100,
		SQ_RD   = 6'b00_1000,
		SQ_TXT  = 6'b01_0000,
		SQ_TERM = 6'b10_0000
	} seq_t;

	typedef struct packed {
		logic byte_load;
		logic frame_clr;
		logic stamp_acc;
		logic name_load;
		logic name_clr;
		logic type_load;
		logic mag_acc;
		logic mag_clr;
		logic text_wr;
		logic text_clr;
		logic ovf_set;
		logic rd_en;
		logic emit_int;
		logic neg;
		logic emit_txt;
		logic emit_term;
	} cmd_t;

	typedef struct packed {
		logic is_stx;
		logic is_etx;
		logic is_gs;
		logic is_rs;
		logic is_minus;
		logic is_digit;
		logic type_int;
		logic type_str;
		logic text_full;
		logic rd_more;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/flp_ram.sv
module flp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/flp_ctrl.sv
module flp_ctrl
	import flp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	seq_t   sq_q, sq_d;
	phase_t ph_q, ph_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= SQ_IDLE;
			ph_q <= PH_STANDBY;
		end else begin
			sq_q <= sq_d;
			ph_q <= ph_d;
		end
	end

	always_comb begin
		cmd      = '0;
		sq_d     = sq_q;
		ph_d     = ph_q;
		s_tready = 1'b0;
		case (sq_q)
			SQ_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.byte_load = 1'b1;
					sq_d          = SQ_STEP;
				end
			end
			SQ_STEP: begin
				sq_d = SQ_IDLE;
				if (st.is_stx) begin
					// STX restarts the frame from any phase.
					cmd.frame_clr = 1'b1;
					ph_d          = PH_STAMP;
				end else begin
					case (ph_q)
						PH_STANDBY: begin
						end
						PH_STAMP: begin
							if (st.is_gs) begin
								ph_d = PH_NAME;
							end else if (st.is_digit) begin
								cmd.stamp_acc = 1'b1;
							end
						end
						PH_NAME: begin
							if (st.is_etx) begin
								ph_d = PH_STANDBY;
							end else if (st.is_rs) begin
								ph_d = PH_TYPE;
							end else begin
								cmd.name_load = 1'b1;
							end
						end
						PH_TYPE: begin
							if (st.is_rs) begin
								if (st.type_int) begin
									ph_d = PH_INT;
								end else if (st.type_str) begin
									ph_d = PH_TEXT;
								end else begin
									ph_d = PH_SKIP;
								end
							end else begin
								cmd.type_load = 1'b1;
							end
						end
						PH_INT, PH_NEG: begin
							if (st.is_gs) begin
								sq_d = SQ_INT;
							end else if (st.is_digit) begin
								cmd.mag_acc = 1'b1;
							end else if (st.is_minus && ph_q == PH_INT) begin
								ph_d = PH_NEG;
							end else begin
								ph_d = PH_SKIP;
							end
						end
						PH_TEXT: begin
							if (st.is_gs) begin
								sq_d = SQ_RD;
							end else if (!st.text_full) begin
								cmd.text_wr = 1'b1;
							end else begin
								cmd.ovf_set = 1'b1;
							end
						end
						PH_SKIP: begin
							if (st.is_gs) begin
								ph_d = PH_NAME;
							end
						end
						default: begin
							ph_d = PH_STANDBY;
						end
					endcase
				end
			end
			SQ_INT: begin
				if (st.out_free) begin
					cmd.emit_int = 1'b1;
					cmd.neg      = (ph_q == PH_NEG);
					cmd.name_clr = 1'b1;
					cmd.mag_clr  = 1'b1;
					ph_d         = PH_NAME;
					sq_d         = SQ_IDLE;
				end
			end
			SQ_RD: begin
				if (st.rd_more) begin
					cmd.rd_en = 1'b1;
					sq_d      = SQ_TXT;
				end else begin
					sq_d = SQ_TERM;
				end
			end
			SQ_TXT: begin
				if (st.out_free) begin
					cmd.emit_txt = 1'b1;
					sq_d         = SQ_RD;
				end
			end
			SQ_TERM: begin
				if (st.out_free) begin
					cmd.emit_term = 1'b1;
					cmd.name_clr  = 1'b1;
					cmd.text_clr  = 1'b1;
					ph_d          = PH_NAME;
					sq_d          = SQ_IDLE;
				end
			end
			default: begin
				sq_d = SQ_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/flp_datapath.sv
module flp_datapath
	import flp_pkg::*;
#(
	parameter int TEXT_DEPTH = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  cmd_t               cmd,
	input  logic [7:0]         int_code,
	input  logic [7:0]         str_code,
	output status_t            st,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser,
	output logic               m_tlast
);

	localparam int CW = $clog2(TEXT_DEPTH + 1);
	localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

	logic [7:0]        byte_q;
	logic [31:0]       stamp_q;
	logic [7:0]        name_q;
	logic [7:0]        type_q;
	logic [31:0]       mag_q;
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [CW-1:0]     rd_idx_q;
	logic [7:0]        rd_data;
	logic [31:0]       digit;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [7:0]        out_name_q;
	logic [31:0]       out_stamp_q;
	logic signed [31:0] out_value_q;
	logic [7:0]        out_text_q;
	logic              out_last_q;
	logic              out_trunc_q;

	// ASCII digits carry their value in the low nibble.
	assign digit = {28'd0, byte_q[3:0]};

	assign st.is_stx    = (byte_q == CH_STX);
	assign st.is_etx    = (byte_q == CH_ETX);
	assign st.is_gs     = (byte_q == CH_GS);
	assign st.is_rs     = (byte_q == CH_RS);
	assign st.is_minus  = (byte_q == CH_MINUS);
	assign st.is_digit  = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
	assign st.type_int  = (type_q == int_code);
	assign st.type_str  = (type_q == str_code);
	assign st.text_full = (count_q == CW'(TEXT_DEPTH));
	assign st.rd_more   = (rd_idx_q < count_q);
	assign st.out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.byte_load) begin
			byte_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q  <= '0;
			name_q   <= '0;
			type_q   <= '0;
			mag_q    <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.frame_clr) begin
				stamp_q <= '0;
			end else if (cmd.stamp_acc) begin
				stamp_q <= (stamp_q << 3) + (stamp_q << 1) + digit;
			end
			if (cmd.frame_clr || cmd.name_clr) begin
				name_q <= '0;
			end else if (cmd.name_load) begin
				name_q <= byte_q;
			end
			if (cmd.frame_clr) begin
				type_q <= '0;
			end else if (cmd.type_load) begin
				type_q <= byte_q;
			end
			if (cmd.frame_clr || cmd.mag_clr) begin
				mag_q <= '0;
			end else if (cmd.mag_acc) begin
				mag_q <= (mag_q << 3) + (mag_q << 1) + digit;
			end
			if (cmd.frame_clr || cmd.text_clr) begin
				count_q  <= '0;
				ovf_q    <= 1'b0;
				rd_idx_q <= '0;
			end else begin
				if (cmd.text_wr) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.ovf_set) begin
					ovf_q <= 1'b1;
				end
				if (cmd.emit_txt) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end
		end
	end

	flp_ram #(
		.WIDTH(8),
		.DEPTH(TEXT_DEPTH)
	) u_text_ram (
		.clk     (clk),
		.wr_en   (cmd.text_wr),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (byte_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Output register: the parser keeps taking bytes while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_int || cmd.emit_txt || cmd.emit_term) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_int || cmd.emit_txt || cmd.emit_term) begin
			out_name_q  <= name_q;
			out_stamp_q <= stamp_q;
		end
		if (cmd.emit_int) begin
			out_kind_q  <= KIND_INT;
			out_value_q <= cmd.neg ? $signed(32'd0 - mag_q) : $signed(mag_q);
			out_text_q  <= '0;
			out_last_q  <= 1'b1;
			out_trunc_q <= 1'b0;
		end else if (cmd.emit_txt) begin
			out_kind_q  <= KIND_TEXT;
			out_value_q <= '0;
			out_text_q  <= rd_data;
			out_last_q  <= 1'b0;
			out_trunc_q <= ovf_q;
		end else if (cmd.emit_term) begin
			out_kind_q  <= KIND_TEXT;
			out_value_q <= '0;
			out_text_q  <= '0;
			out_last_q  <= 1'b1;
			out_trunc_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_text_q, out_value_q, out_stamp_q, out_name_q};
	assign m_tuser  = {out_trunc_q, out_kind_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/framed_log_record_parser.sv
// Channel   Direction  Payload
// s_*       in         s_tdata: rx_byte
// m_*       out        m_tdata: source_name, stamp, int_value, text_byte; tuser: kind, truncated
// APB       in/out     int_type_code at 0x0, string_type_code at 0x4
//
// A received byte is captured (SQ_IDLE) and then updates the parse state (SQ_STEP).
// An integer record adds a state that loads its result (SQ_INT). A string record reads each
// buffered byte via the registered read port (SQ_RD), loads it (SQ_TXT), and ends in SQ_TERM.
// Reset is asynchronous; no clearing pass is needed after it.
// A stalled output holds the sequencer only when a new result must be loaded.
module framed_log_record_parser
	import flp_pkg::*;
#(
	parameter int TEXT_DEPTH = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] rx_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [7:0] source_name, [39:8] stamp,
	                                      // [71:40] int_value, [79:72] text_byte
	output logic [TUSER_W-1:0] m_tuser,   // [0] record_kind, [1] truncated
	output logic               m_tlast,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [7:0] int_code_q;
	logic [7:0] str_code_q;
	logic       cfg_wr;
	cmd_t       cmd;
	status_t    st;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_code_q <= INT_CODE_RESET;
			str_code_q <= STR_CODE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_INT_CODE) begin
				int_code_q <= pwdata[7:0];
			end else begin
				str_code_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_STR_CODE) ? {24'd0, str_code_q} : {24'd0, int_code_q};

	flp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	flp_datapath #(
		.TEXT_DEPTH(TEXT_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.int_code (int_code_q),
		.str_code (str_code_q),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A new result is only loaded when the output register is empty or draining.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_int || cmd.emit_txt || cmd.emit_term) |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending transfer");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.byte_load, cmd.emit_int, cmd.emit_txt, cmd.emit_term}))
		else $error("more than one sequencer action in a cycle");

	a_no_buffer_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.text_wr |-> !st.text_full)
		else $error("text buffer written while full");

	// Every flushed byte goes back through a buffer read before the next result.
	a_flush_paced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_txt |=> !(cmd.emit_txt || cmd.emit_term))
		else $error("text results loaded on consecutive cycles");

endmodule
